/* design/c2s_pkg.sv */
// Shared types and constants of the Cartesian to spherical converter.
// Holds the arctangent table, the CORDIC gain and the angle limits.
// Depends on nothing.
`default_nettype none

package c2s_pkg;

  localparam int GUARD_BITS = 24;
  localparam int ATAN_LEN = 24;
  localparam logic signed [25:0] GAIN_Q24 = 26'sd27628053;
  localparam logic [31:0] ACC_HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] ANGLE_ROUND = 32'h0000_8000;
  localparam logic signed [15:0] EL_MAX = 16'sd16384;
  localparam logic signed [15:0] EL_MIN = -16'sd16384;
  localparam logic [17:0] RADIUS_MAX = 18'h3FFFF;

  typedef struct packed {
    logic zero;
    logic z_pos;
    logic z_neg;
  } c2s_flags_t;

  typedef struct packed {
    logic [31:0] az_acc;
    logic [31:0] el_acc;
    c2s_flags_t flags;
  } cord_raw_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0: val = 32'd536870912;
      5'd1: val = 32'd316933406;
      5'd2: val = 32'd167458907;
      5'd3: val = 32'd85004756;
      5'd4: val = 32'd42667331;
      5'd5: val = 32'd21354465;
      5'd6: val = 32'd10679838;
      5'd7: val = 32'd5340245;
      5'd8: val = 32'd2670163;
      5'd9: val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* design/cartesian_to_spherical_core.sv */
// Pipelined Cartesian to spherical converter: two chained CORDIC pipelines
// for azimuth and elevation and a digit-by-digit square root for the radius.
// Depends on c2s_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   input   | in_coord_x, in_coord_y, in_coord_z      | start high, busy low
//   result  | out_azimuth, out_elevation, out_radius  | out_valid, one cycle
//
// One point is taken in every cycle while busy is low. Latency is set by the
// two chained CORDIC pipelines or by the square-root pipeline, whichever is
// longer. Reset is synchronous and clears the valid bits only; busy is high
// while reset is asserted. The receiver cannot stall, so no stage ever holds.
`default_nettype none

module cartesian_to_spherical_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_coord_z,
  output logic                               out_valid,
  output logic signed [15:0]                 out_azimuth,
  output logic signed [15:0]                 out_elevation,
  output logic [17:0]                        out_radius
);

  import c2s_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int S = CORDIC_STAGES;
  localparam int DW = W + GUARD_BITS + 4;
  localparam int SQW = 2 * W;
  localparam int NW = SQW + 4;
  localparam int QW = W + 2;
  localparam int RMW = QW + 2;
  localparam int RXW = (QW + 1 > 18) ? QW + 1 : 18;
  localparam int LAT_C = 2 * S;
  localparam int LAT_R = QW + 1;
  localparam int LMAX = (LAT_C > LAT_R) ? LAT_C : LAT_R;
  localparam int D_C = LMAX - LAT_C;
  localparam int D_R = LMAX - LAT_R;
  localparam int VL = LMAX + 3;

  logic [VL-1:0] vld_r;
  logic [VL-1:0] vld_nxt;

  logic signed [W-1:0] x_r, y_r, z_r;

  logic signed [DW-1:0] cx_r [0:2*S];
  logic signed [DW-1:0] cy_r [0:2*S];
  logic [31:0] ac_r [0:2*S];
  logic [31:0] as_r [S+1:2*S];
  logic signed [DW-1:0] zg_r [0:S];
  c2s_flags_t fl_r [0:2*S];

  logic [SQW-1:0] xx_r, yy_r, zz_r;
  logic [NW-1:0] nn_r [0:QW];
  logic [QW-1:0] rt_r [0:QW];
  logic [RMW-1:0] rm_r [0:QW];

  logic signed [DW-1:0] cx0_nxt, cy0_nxt, zg0_nxt, z_ext;
  logic [31:0] ac0_nxt;
  c2s_flags_t fl0_nxt;
  logic signed [SQW-1:0] xx_nxt, yy_nxt, zz_nxt;
  logic signed [SQW-1:0] x_sq, y_sq, z_sq;
  logic [SQW-1:0] sum_nxt;

  cord_raw_t cord_raw, cord_al;
  logic [QW+RMW-1:0] rad_raw, rad_al;

  logic [31:0] az_rnd, el_rnd;
  logic signed [15:0] el_cl;
  logic [QW-1:0] q_al;
  logic [RMW-1:0] rem_al;
  logic [RXW-1:0] r_ext;
  logic signed [15:0] az_nxt, el_nxt;
  logic [17:0] rad_nxt;

  assign busy = ~rst_n;
  assign vld_nxt = {vld_r[VL-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= in_coord_x;
    y_r <= in_coord_y;
    z_r <= in_coord_z;
  end

  always_comb begin
    cx0_nxt = $signed({{(DW-W-GUARD_BITS){x_r[W-1]}}, x_r, {GUARD_BITS{1'b0}}});
    cy0_nxt = $signed({{(DW-W-GUARD_BITS){y_r[W-1]}}, y_r, {GUARD_BITS{1'b0}}});
    ac0_nxt = '0;
    if (x_r[W-1]) begin
      cx0_nxt = -cx0_nxt;
      cy0_nxt = -cy0_nxt;
      ac0_nxt = ACC_HALF_TURN;
    end
    z_ext = $signed({{(DW-W){z_r[W-1]}}, z_r});
    zg0_nxt = z_ext * $signed({{(DW-26){GAIN_Q24[25]}}, GAIN_Q24});
    fl0_nxt.zero = (x_r == '0) && (y_r == '0);
    fl0_nxt.z_pos = !z_r[W-1] && (z_r != '0);
    fl0_nxt.z_neg = z_r[W-1];
    x_sq = $signed({{W{x_r[W-1]}}, x_r});
    y_sq = $signed({{W{y_r[W-1]}}, y_r});
    z_sq = $signed({{W{z_r[W-1]}}, z_r});
    xx_nxt = x_sq * x_sq;
    yy_nxt = y_sq * y_sq;
    zz_nxt = z_sq * z_sq;
  end

  always_ff @(posedge clk) begin
    cx_r[0] <= cx0_nxt;
    cy_r[0] <= cy0_nxt;
    ac_r[0] <= ac0_nxt;
    zg_r[0] <= zg0_nxt;
    fl_r[0] <= fl0_nxt;
    xx_r <= xx_nxt;
    yy_r <= yy_nxt;
    zz_r <= zz_nxt;
  end

  for (genvar j = 0; j < 2 * S; j++) begin : g_cord
    localparam int I = (j < S) ? j : j - S;
    logic signed [DW-1:0] x_in, y_in, xs, ys;
    logic [31:0] a_in, step;

    if (j == S) begin : g_join
      assign y_in = zg_r[S];
      assign a_in = '0;
    end else begin : g_pass
      assign y_in = cy_r[j];
      assign a_in = ac_r[j];
    end

    assign x_in = cx_r[j];
    assign xs = x_in >>> I;
    assign ys = y_in >>> I;
    assign step = atan_entry(5'(I));

    always_ff @(posedge clk) begin
      if (!y_in[DW-1]) begin
        cx_r[j+1] <= x_in + ys;
        cy_r[j+1] <= y_in - xs;
        ac_r[j+1] <= a_in + step;
      end else begin
        cx_r[j+1] <= x_in - ys;
        cy_r[j+1] <= y_in + xs;
        ac_r[j+1] <= a_in - step;
      end
      fl_r[j+1] <= fl_r[j];
    end

    if (j < S) begin : g_zg
      always_ff @(posedge clk) begin
        zg_r[j+1] <= zg_r[j];
      end
    end else if (j == S) begin : g_az_save
      always_ff @(posedge clk) begin
        as_r[j+1] <= ac_r[S];
      end
    end else begin : g_az_keep
      always_ff @(posedge clk) begin
        as_r[j+1] <= as_r[j];
      end
    end
  end

  assign sum_nxt = xx_r + yy_r + zz_r;

  always_ff @(posedge clk) begin
    nn_r[0] <= {sum_nxt, 4'b0000};
    rt_r[0] <= '0;
    rm_r[0] <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    logic [RMW-1:0] rm_sh, trial;

    assign rm_sh = {rm_r[k][RMW-3:0], nn_r[k][NW-1 -: 2]};
    assign trial = {rt_r[k], 2'b01};

    always_ff @(posedge clk) begin
      nn_r[k+1] <= {nn_r[k][NW-3:0], 2'b00};
      if (rm_sh >= trial) begin
        rm_r[k+1] <= rm_sh - trial;
        rt_r[k+1] <= {rt_r[k][QW-2:0], 1'b1};
      end else begin
        rm_r[k+1] <= rm_sh;
        rt_r[k+1] <= {rt_r[k][QW-2:0], 1'b0};
      end
    end
  end

  assign cord_raw.az_acc = as_r[2*S];
  assign cord_raw.el_acc = ac_r[2*S];
  assign cord_raw.flags = fl_r[2*S];
  assign rad_raw = {rt_r[QW], rm_r[QW]};

  if (D_C > 0) begin : g_dly_c
    cord_raw_t dc_r [0:D_C-1];
    always_ff @(posedge clk) begin
      dc_r[0] <= cord_raw;
    end
    for (genvar m = 1; m < D_C; m++) begin : g_tap
      always_ff @(posedge clk) begin
        dc_r[m] <= dc_r[m-1];
      end
    end
    assign cord_al = dc_r[D_C-1];
  end else begin : g_nodly_c
    assign cord_al = cord_raw;
  end

  if (D_R > 0) begin : g_dly_r
    logic [QW+RMW-1:0] dr_r [0:D_R-1];
    always_ff @(posedge clk) begin
      dr_r[0] <= rad_raw;
    end
    for (genvar m = 1; m < D_R; m++) begin : g_tap
      always_ff @(posedge clk) begin
        dr_r[m] <= dr_r[m-1];
      end
    end
    assign rad_al = dr_r[D_R-1];
  end else begin : g_nodly_r
    assign rad_al = rad_raw;
  end

  always_comb begin
    az_rnd = cord_al.az_acc + ANGLE_ROUND;
    el_rnd = cord_al.el_acc + ANGLE_ROUND;
    el_cl = $signed(el_rnd[31:16]);
    if (el_cl > EL_MAX) begin
      el_cl = EL_MAX;
    end else if (el_cl < EL_MIN) begin
      el_cl = EL_MIN;
    end
    if (cord_al.flags.zero) begin
      az_nxt = '0;
      if (cord_al.flags.z_pos) begin
        el_nxt = EL_MAX;
      end else if (cord_al.flags.z_neg) begin
        el_nxt = EL_MIN;
      end else begin
        el_nxt = '0;
      end
    end else begin
      az_nxt = $signed(az_rnd[31:16]);
      el_nxt = el_cl;
    end

    q_al = rad_al[QW+RMW-1:RMW];
    rem_al = rad_al[RMW-1:0];
    r_ext = {{(RXW-QW){1'b0}}, q_al} + RXW'((rem_al > {2'b00, q_al}) ? 1 : 0);
    if (r_ext > RXW'(RADIUS_MAX)) begin
      rad_nxt = RADIUS_MAX;
    end else begin
      rad_nxt = r_ext[17:0];
    end
  end

  always_ff @(posedge clk) begin
    out_azimuth <= az_nxt;
    out_elevation <= el_nxt;
    out_radius <= rad_nxt;
  end

  assign out_valid = vld_r[VL-1];

endmodule

`default_nettype wire

/* bench/cartesian_to_spherical_core_tb.sv */
// Self-checking bench for cartesian_to_spherical_core: directed and random points
// are checked word by word against an in-bench CORDIC and square-root predictor.
// Depends on the core RTL and c2s_pkg.
`timescale 1ns / 1ps

module cartesian_to_spherical_core_tb;

  localparam int STAGES = 16;
  localparam int COORD_W = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 460;

  typedef struct {
    logic signed [15:0] azimuth;
    logic signed [15:0] elevation;
    logic [17:0]        radius;
  } sph_word_t;

  class spherical_ledger;
    localparam longint GUARD_SCALE = 64'sd16777216;
    localparam longint ELEV_GAIN = 64'sd27628053;
    localparam bit [31:0] HALF_TURN = 32'h8000_0000;
    localparam longint RADIUS_CAP = 64'sd262143;

    sph_word_t awaited[$];
    int mismatches;
    bit [31:0] arctan_q32 [24];

    function new();
      mismatches = 0;
      arctan_q32 = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
      };
    endfunction

    // Vectoring rotations drive vy toward zero and sum the turned angle.
    function void sweep_vector(inout longint vx, inout longint vy, inout bit [31:0] acc);
      longint xs;
      longint ys;
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx = vx + ys;
          vy = vy - xs;
          acc = acc + arctan_q32[i];
        end else begin
          vx = vx - ys;
          vy = vy + xs;
          acc = acc - arctan_q32[i];
        end
      end
    endfunction

    function logic signed [15:0] acc_to_angle(bit [31:0] acc);
      bit [31:0] rounded;
      rounded = acc + 32'h0000_8000;
      return rounded[31:16];
    endfunction

    function longint floor_root(longint n);
      longint root;
      longint cand;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
        cand = root | (64'sd1 << b);
        if (cand * cand <= n) root = cand;
      end
      return root;
    endfunction

    function sph_word_t to_spherical(longint x, longint y, longint z);
      sph_word_t w;
      longint cx;
      longint cy;
      longint ex;
      longint ez;
      longint sq;
      longint r;
      bit [31:0] acc;
      int el;
      w.azimuth = '0;
      w.elevation = '0;
      if (x == 0 && y == 0) begin
        w.elevation = (z > 0) ? 16'sd16384 : ((z < 0) ? -16'sd16384 : 16'sd0);
      end else begin
        cx = x * GUARD_SCALE;
        cy = y * GUARD_SCALE;
        acc = '0;
        if (cx < 0) begin
          cx = -cx;
          cy = -cy;
          acc = HALF_TURN;
        end
        sweep_vector(cx, cy, acc);
        w.azimuth = acc_to_angle(acc);
        ex = cx;
        ez = z * ELEV_GAIN;
        acc = '0;
        sweep_vector(ex, ez, acc);
        el = acc_to_angle(acc);
        if (el > 16384) el = 16384;
        if (el < -16384) el = -16384;
        w.elevation = el[15:0];
      end
      // Rounding half up of 4*sqrt(s) equals the halved root of 64*s, rounded up.
      sq = x * x + y * y + z * z;
      r = (floor_root(64 * sq) + 1) >>> 1;
      if (r > RADIUS_CAP) r = RADIUS_CAP;
      w.radius = r[17:0];
      return w;
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
      awaited.push_back(to_spherical(x, y, z));
    endfunction

    function void check_result(logic signed [15:0] az, logic signed [15:0] el,
                               logic [17:0] rad);
      sph_word_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: az %0d el %0d radius %0d", az, el, rad);
        return;
      end
      want = awaited.pop_front();
      if (want.azimuth !== az || want.elevation !== el || want.radius !== rad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected az %0d el %0d radius %0d, got az %0d el %0d radius %0d",
                   want.azimuth, want.elevation, want.radius, az, el, rad);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic out_valid;
  logic signed [15:0] out_azimuth;
  logic signed [15:0] out_elevation;
  logic [17:0] out_radius;

  spherical_ledger ledger = new();
  int cycle_count = 0;

  cartesian_to_spherical_core #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH(COORD_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z),
    .out_valid(out_valid),
    .out_azimuth(out_azimuth),
    .out_elevation(out_elevation),
    .out_radius(out_radius)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cartesian_to_spherical_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_result(out_azimuth, out_elevation, out_radius);
      if (start && !busy) ledger.note_point(in_coord_x, in_coord_y, in_coord_z);
    end
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    @(negedge clk);
    start <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic sender_gap(int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord();
    logic [31:0] raw;
    logic signed [15:0] v;
    raw = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = -16'sd32768;
          1: v = -16'sd1;
          2: v = 16'sd0;
          3: v = 16'sd1;
          default: v = 16'sd32767;
        endcase
      end
      1: v = 16'($signed($urandom_range(16)) - 8);
      2: v = 16'sd0;
      default: v = raw[15:0];
    endcase
    return v;
  endfunction

  task automatic random_points(int count, int idle_pct);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    for (int n = 0; n < count; n++) begin
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      if ($urandom_range(9) == 0) begin
        x = '0;
        y = '0;
      end
      sender_gap(idle_pct);
      send_point(x, y, z);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd0, 16'sd32767);
    send_point(16'sd0, 16'sd0, -16'sd32768);
    send_point(16'sd0, 16'sd0, 16'sd1);
    send_point(16'sd0, 16'sd0, -16'sd1);
    sender_gap(17);
    send_point(16'sd32767, 16'sd0, 16'sd0);
    send_point(-16'sd32768, 16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd32767, 16'sd0);
    send_point(16'sd0, -16'sd32768, 16'sd0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    sender_gap(17);
    send_point(-16'sd32768, 16'sd1, 16'sd0);
    send_point(-16'sd32768, -16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0, 16'sd7);
    send_point(16'sd1, 16'sd0, 16'sd32767);
    send_point(-16'sd1, 16'sd0, -16'sd32768);
    send_point(16'sd1, 16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1, -16'sd1);
    send_point(16'sd32767, -16'sd32768, 16'sd5);
    send_point(16'sd0, 16'sd1, -16'sd32768);
    send_point(16'sd12345, -16'sd23456, 16'sd3456);
    send_point(-16'sd21846, 16'sd10923, -16'sd5461);
    drain_results();

    random_points(RANDOM_PER_PHASE, 17);
    random_points(RANDOM_PER_PHASE / 2, 64);
    drain_results();
    random_points(RANDOM_PER_PHASE / 2, 64);
    random_points(RANDOM_PER_PHASE, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("cartesian_to_spherical_core test passed");
    end else begin
      $display("cartesian_to_spherical_core test failed");
    end
    $finish;
  end

endmodule
